// ===== src/tgim_pkg.sv =====
// Package for the tensor gather index map: shared constants and register codes.
// No dependencies; the other files but tgim_stride refer to it by scoped names.
package tgim_pkg;

   localparam int QW         = 32;  // out_index / in_index word width
   localparam int STEP_BITS  = 4;   // quotient bits resolved per divider stage
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int RANK_W     = 3;
   localparam int PERM_W     = 2;
   localparam int PERM_REG_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE   = 3'd0,
      REG_RANK   = 3'd1,
      REG_INDIMS = 3'd2,
      REG_OUTDIM = 3'd3,
      REG_PERM   = 3'd4,
      REG_STARTS = 3'd5,
      REG_STEPS  = 3'd6
   } csr_reg_type;

   localparam logic MODE_TRANSPOSE = 1'b0;
   localparam logic MODE_SLICE     = 1'b1;

endpackage

// ===== src/tgim_if.sv =====
// Handshake interfaces for the request and response words.
// Depends on tgim_pkg for the word width.
interface tgim_req_if;
   logic                   valid;
   logic                   ready;
   logic [tgim_pkg::QW-1:0] out_index;
   modport source (output valid, output out_index, input ready);
   modport sink   (input valid, input out_index, output ready);
endinterface

interface tgim_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [tgim_pkg::QW-1:0] in_index;
   logic                   out_of_range;
   modport source (output valid, output in_index, output out_of_range, input ready);
   modport sink   (input valid, input in_index, input out_of_range, output ready);
endinterface

// ===== src/tgim_stride.sv =====
// Input stride table, rebuilt every cycle from the dims and rank registers.
// No package dependency; after a register write the strides settle from the innermost axis outward.
module tgim_stride #(
   parameter int MAX_RANK    = 4,
   parameter int DIM_WIDTH   = 16,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_RANK+1)-1:0]   eff_rank,
   input  logic [MAX_RANK*DIM_WIDTH-1:0]   in_dims,
   output logic [MAX_RANK*INDEX_WIDTH-1:0] strides
);
   localparam int DW = DIM_WIDTH;
   localparam int IW = INDEX_WIDTH;

   logic [IW-1:0] stride_ff [MAX_RANK];
   logic [IW-1:0] stride_in [MAX_RANK];

   for (genvar d = 0; d < MAX_RANK; d++) begin : g_axis
      if (d == MAX_RANK - 1) begin : g_last
         assign stride_in[d] = IW'(1);
      end else begin : g_inner
         logic [IW+DW-1:0] prod;
         assign prod = stride_ff[d+1] * in_dims[(d+1)*DW +: DW];
         // innermost used axis has unit stride
         assign stride_in[d] = (d + 1 >= int'(eff_rank)) ? IW'(1) : prod[IW-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stride_ff[d] <= IW'(1);
         end else begin
            stride_ff[d] <= stride_in[d];
         end
      end
      assign strides[d*IW +: IW] = stride_ff[d];
   end
endmodule

// ===== src/tgim_decode.sv =====
// Mixed-radix decode of the output index: a pipelined restoring divider per axis.
// Depends on tgim_pkg; STEP_BITS quotient bits per stage, innermost axis first.
module tgim_decode #(
   parameter int MAX_RANK  = 4,
   parameter int DIM_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [tgim_pkg::QW-1:0]       in_q,
   input  logic [MAX_RANK*DIM_WIDTH-1:0] out_dims,
   input  logic [$clog2(MAX_RANK+1)-1:0] eff_rank,
   output logic                          out_valid,
   output logic [MAX_RANK*DIM_WIDTH-1:0] out_coord,
   output logic                          out_bad
);
   localparam int DW  = DIM_WIDTH;
   localparam int QW  = tgim_pkg::QW;
   localparam int SB  = tgim_pkg::STEP_BITS;
   localparam int SPA = QW / SB;
   localparam int NS  = MAX_RANK * SPA;
   localparam int CW  = MAX_RANK * DW;

   logic [NS-1:0] v_ff;
   logic [QW-1:0] q_ff     [NS];
   logic [QW-1:0] q0_ff    [NS];
   logic [DW-1:0] rem_ff   [NS];
   logic [CW-1:0] coord_ff [NS];
   logic [NS-1:0] bad_ff;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int A = MAX_RANK - 1 - s / SPA;
      localparam bit FIRST = (s % SPA) == 0;
      localparam bit LAST  = (s % SPA) == SPA - 1;

      logic          v_src, bad_src, bad_n;
      logic [QW-1:0] qp_src, q_src, q0_src, q_n;
      logic [DW-1:0] rem_src, rem_n;
      logic [CW-1:0] coord_src, coord_n;
      logic [DW-1:0] od;

      assign od = out_dims[A*DW +: DW];

      if (s == 0) begin : g_head
         assign v_src     = in_valid;
         assign qp_src    = in_q;
         assign q0_src    = in_q;
         assign rem_src   = '0;
         assign coord_src = '0;
         assign bad_src   = 1'b0;
      end else begin : g_body
         assign v_src     = v_ff[s-1];
         assign qp_src    = q_ff[s-1];
         assign q0_src    = FIRST ? q_ff[s-1] : q0_ff[s-1];
         assign rem_src   = FIRST ? '0 : rem_ff[s-1];
         assign coord_src = coord_ff[s-1];
         assign bad_src   = bad_ff[s-1];
      end
      assign q_src = qp_src;

      always_comb begin
         logic [DW:0]   t;
         logic [QW-1:0] qt;
         logic [DW-1:0] rt;
         logic          active;
         qt = q_src;
         rt = rem_src;
         for (int i = 0; i < SB; i++) begin
            t  = {rt, qt[QW-1]};
            qt = {qt[QW-2:0], 1'b0};
            if (t >= {1'b0, od}) begin
               t     = t - {1'b0, od};
               qt[0] = 1'b1;
            end
            rt = t[DW-1:0];
         end
         q_n     = qt;
         rem_n   = rt;
         coord_n = coord_src;
         bad_n   = bad_src;
         active  = A < int'(eff_rank);
         if (LAST) begin
            // unused axis or zero dim: quotient passes through untouched
            if (active && od != '0) begin
               coord_n[A*DW +: DW] = rt;
            end else begin
               q_n                 = q0_src;
               coord_n[A*DW +: DW] = '0;
            end
            bad_n = bad_src | (active && od == '0);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]     <= q_n;
            q0_ff[s]    <= q0_src;
            rem_ff[s]   <= rem_n;
            coord_ff[s] <= coord_n;
            bad_ff[s]   <= bad_n;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_coord = coord_ff[NS-1];
   // leftover quotient means the index is past the output count
   assign out_bad   = bad_ff[NS-1] | (q_ff[NS-1] != '0);
endmodule

// ===== src/tgim_map.sv =====
// Coordinate to source index mapping: per-axis products, slice bound check, sum.
// Depends on tgim_pkg; four register stages, output register last.
module tgim_map #(
   parameter int MAX_RANK    = 4,
   parameter int DIM_WIDTH   = 16,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [MAX_RANK*DIM_WIDTH-1:0]            in_coord,
   input  logic                                     in_bad,
   input  logic                                     mode,
   input  logic [$clog2(MAX_RANK+1)-1:0]            eff_rank,
   input  logic [MAX_RANK*tgim_pkg::PERM_W-1:0]     perm,
   input  logic [MAX_RANK*DIM_WIDTH-1:0]            in_dims,
   input  logic [MAX_RANK*DIM_WIDTH-1:0]            starts,
   input  logic [MAX_RANK*DIM_WIDTH-1:0]            steps,
   input  logic [MAX_RANK*INDEX_WIDTH-1:0]          strides,
   output logic                                     out_valid,
   output logic [tgim_pkg::QW-1:0]                  out_index,
   output logic                                     out_bad
);
   localparam int DW  = DIM_WIDTH;
   localparam int IW  = INDEX_WIDTH;
   localparam int PW  = tgim_pkg::PERM_W;
   localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

   logic [IW-1:0] stride_arr [MAX_RANK];

   // stage 1: products
   logic                   v1_ff, bad1_ff;
   logic [IW-1:0]          tp1_ff [MAX_RANK];
   logic signed [2*DW:0]   sp1_ff [MAX_RANK];
   // stage 2: slice coordinate and bound check
   logic                   v2_ff, bad2_ff;
   logic [IW-1:0]          tp2_ff [MAX_RANK];
   logic [DW-1:0]          x2_ff  [MAX_RANK];
   logic [MAX_RANK-1:0]    oob2_ff;
   // stage 3: per-axis terms
   logic                   v3_ff, bad3_ff;
   logic [IW-1:0]          term3_ff [MAX_RANK];
   // stage 4: output register
   logic                   v4_ff, bad4_ff;
   logic [IW-1:0]          acc4_ff;

   for (genvar d = 0; d < MAX_RANK; d++) begin : g_axis
      logic [PW-1:0]        ax;
      logic [IW-1:0]        sel;
      logic [DW+IW-1:0]     tfull;
      logic signed [2*DW:0] sprod;
      logic signed [2*DW+1:0] x;
      logic                 oob;
      logic [DW+IW-1:0]     xfull;
      logic [IW-1:0]        term;
      logic                 active;

      assign stride_arr[d] = strides[d*IW +: IW];
      assign active = d < int'(eff_rank);
      assign ax     = perm[d*PW +: PW];
      assign sel    = (int'(ax) < int'(eff_rank)) ? stride_arr[AXW'(ax)] : '0;
      assign tfull  = in_coord[d*DW +: DW] * sel;
      assign sprod  = $signed({1'b0, in_coord[d*DW +: DW]}) * $signed(steps[d*DW +: DW]);

      assign x   = $signed({{(DW+2){1'b0}}, starts[d*DW +: DW]}) + sp1_ff[d];
      assign oob = (x < 0) || (x >= $signed({{(DW+2){1'b0}}, in_dims[d*DW +: DW]}));

      assign xfull = x2_ff[d] * stride_arr[d];
      assign term  = !active ? '0 : (mode == tgim_pkg::MODE_SLICE) ? xfull[IW-1:0]
                                                                     : tp2_ff[d];

      always_ff @(posedge clock) begin
         if (en) begin
            tp1_ff[d]   <= tfull[IW-1:0];
            sp1_ff[d]   <= sprod;
            tp2_ff[d]   <= tp1_ff[d];
            x2_ff[d]    <= x[DW-1:0];
            oob2_ff[d]  <= active && (mode == tgim_pkg::MODE_SLICE) && oob;
            term3_ff[d] <= term;
         end
      end
   end

   logic [IW-1:0] sum;
   always_comb begin
      sum = '0;
      for (int d = 0; d < MAX_RANK; d++) begin
         sum = sum + term3_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad1_ff <= in_bad;
         bad2_ff <= bad1_ff;
         bad3_ff <= bad2_ff | (|oob2_ff);
         bad4_ff <= bad3_ff;
         acc4_ff <= bad3_ff ? '0 : sum;
      end
   end

   assign out_valid = v4_ff;
   assign out_index = tgim_pkg::QW'(acc4_ff);
   assign out_bad   = bad4_ff;
endmodule

// ===== src/tensor_gather_index_map.sv =====
// Top level of the tensor gather index map: registers, stride table, decode, map.
// Depends on tgim_pkg, tgim_if, tgim_stride, tgim_decode, tgim_map.
//
//   port      dir   word                          accepted when
//   req_ch    in    out_index                     valid && ready
//   rsp_ch    out   in_index, out_of_range        valid && ready
//   csr_*     in    csr_index, csr_wdata          csr_we
//
// One word enters per cycle while rsp_ch is not stalled. Words pass the divider
// stages (4 quotient bits per stage, one divider chain per axis), then tgim_map.
// Reset is synchronous, active high; it empties the pipeline and loads the
// register defaults. A stall on rsp_ch freezes every stage and drops req_ch.ready
// unless the last stage is empty.
module tensor_gather_index_map #(
   parameter int MAX_RANK    = 4,
   parameter int DIM_WIDTH   = 16,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   tgim_req_if.sink                          req_ch,
   tgim_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [tgim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tgim_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int DW  = DIM_WIDTH;
   localparam int IW  = INDEX_WIDTH;
   localparam int ERW = $clog2(MAX_RANK + 1);
   localparam int PW  = tgim_pkg::PERM_W;
   localparam int CDW = tgim_pkg::CSR_DATA_W;

   logic                         mode_ff;
   logic [tgim_pkg::RANK_W-1:0]  rank_ff;
   logic [CDW-1:0]               in_dims_ff, out_dims_ff, starts_ff, steps_ff;
   logic [tgim_pkg::PERM_REG_W-1:0] perm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= tgim_pkg::MODE_TRANSPOSE;
         rank_ff     <= tgim_pkg::RANK_W'(1);
         in_dims_ff  <= '0;
         out_dims_ff <= '0;
         perm_ff     <= tgim_pkg::PERM_REG_W'(228);
         starts_ff   <= '0;
         steps_ff    <= 64'h0001_0001_0001_0001;
      end else if (csr_we) begin
         unique case (tgim_pkg::csr_reg_type'(csr_index))
            tgim_pkg::REG_MODE:   mode_ff     <= csr_wdata[0];
            tgim_pkg::REG_RANK:   rank_ff     <= csr_wdata[tgim_pkg::RANK_W-1:0];
            tgim_pkg::REG_INDIMS: in_dims_ff  <= csr_wdata;
            tgim_pkg::REG_OUTDIM: out_dims_ff <= csr_wdata;
            tgim_pkg::REG_PERM:   perm_ff     <= csr_wdata[tgim_pkg::PERM_REG_W-1:0];
            tgim_pkg::REG_STARTS: starts_ff   <= csr_wdata;
            tgim_pkg::REG_STEPS:  steps_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // rank zero acts as one, above MAX_RANK saturates
   logic [ERW-1:0] eff_rank;
   assign eff_rank = (rank_ff == '0) ? ERW'(1) :
                     (int'(rank_ff) > MAX_RANK) ? ERW'(MAX_RANK) : ERW'(rank_ff);

   // per-axis fields; anything past the register reads as zero
   logic [MAX_RANK*DW-1:0] in_dim_v, out_dim_v, start_v, step_v;
   logic [MAX_RANK*PW-1:0] perm_v;
   for (genvar d = 0; d < MAX_RANK; d++) begin : g_field
      assign in_dim_v[d*DW +: DW]  = DW'(in_dims_ff >> (d*DW));
      assign out_dim_v[d*DW +: DW] = DW'(out_dims_ff >> (d*DW));
      assign start_v[d*DW +: DW]   = DW'(starts_ff >> (d*DW));
      assign step_v[d*DW +: DW]    = DW'(steps_ff >> (d*DW));
      assign perm_v[d*PW +: PW]    = PW'(perm_ff >> (d*PW));
   end

   logic [MAX_RANK*IW-1:0] strides;
   tgim_stride #(.MAX_RANK(MAX_RANK), .DIM_WIDTH(DW), .INDEX_WIDTH(IW)) u_stride (
      .clock    (clock),
      .reset    (reset),
      .eff_rank (eff_rank),
      .in_dims  (in_dim_v),
      .strides  (strides)
   );

   logic en;
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   logic                   dec_valid, dec_bad;
   logic [MAX_RANK*DW-1:0] dec_coord;
   tgim_decode #(.MAX_RANK(MAX_RANK), .DIM_WIDTH(DW)) u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_q      (req_ch.out_index),
      .out_dims  (out_dim_v),
      .eff_rank  (eff_rank),
      .out_valid (dec_valid),
      .out_coord (dec_coord),
      .out_bad   (dec_bad)
   );

   tgim_map #(.MAX_RANK(MAX_RANK), .DIM_WIDTH(DW), .INDEX_WIDTH(IW)) u_map (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dec_valid),
      .in_coord  (dec_coord),
      .in_bad    (dec_bad),
      .mode      (mode_ff),
      .eff_rank  (eff_rank),
      .perm      (perm_v),
      .in_dims   (in_dim_v),
      .starts    (start_v),
      .steps     (step_v),
      .strides   (strides),
      .out_valid (rsp_ch.valid),
      .out_index (rsp_ch.in_index),
      .out_bad   (rsp_ch.out_of_range)
   );

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("pipeline not empty after reset");
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while output stalled");
   a_flag_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_of_range |-> rsp_ch.in_index == '0)
      else $error("flagged word carries nonzero index");
endmodule

// ===== tb/tb.sv =====
// Testbench for tensor_gather_index_map: directed and random index words against
// an internal predictor of the transpose and slice mappings.
// Depends on tgim_pkg, tgim_if and the block's RTL.
module tb;

   localparam int LATENCY = 4 * 32 / 4 + 4;
   localparam int LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   tgim_pkg::csr_reg_type csr_index = tgim_pkg::REG_MODE;
   logic [tgim_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tgim_req_if req_ch ();
   tgim_rsp_if rsp_ch ();

   tensor_gather_index_map dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow registers
   logic        m_mode;
   logic [2:0]  m_rank;
   logic [63:0] m_in_dims, m_out_dims, m_starts, m_steps;
   logic [7:0]  m_perm;

   typedef struct packed {
      logic [31:0] in_index;
      logic        out_of_range;
   } src_addr_type;

   src_addr_type src_addr_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int flagged = 0;
   longint cycles = 0;

   function automatic src_addr_type map_index(logic [31:0] oidx);
      src_addr_type r;
      int          rk;
      longint      istr[4];
      longint      coord[4];
      longint      q, od, acc, x, st, stp, lim;
      bit          bad;
      int          ax;
      rk = (m_rank == 0) ? 1 : (m_rank > 4 ? 4 : int'(m_rank));
      q = longint'(oidx);
      acc = 0;
      bad = 0;
      istr[rk-1] = 1;
      for (int d = rk - 2; d >= 0; d--)
         istr[d] = (istr[d+1] * longint'(m_in_dims[16*(d+1) +: 16])) & 64'hFFFF_FFFF;
      for (int d = rk - 1; d >= 0; d--) begin
         od = longint'(m_out_dims[16*d +: 16]);
         if (od == 0) begin
            bad = 1;
            coord[d] = 0;
         end else begin
            coord[d] = q % od;
            q = q / od;
         end
      end
      if (q != 0) bad = 1;
      if (!bad) begin
         for (int d = 0; d < rk; d++) begin
            if (m_mode == tgim_pkg::MODE_TRANSPOSE) begin
               ax = int'(m_perm[2*d +: 2]);
               acc = (acc + coord[d] * ((ax < rk) ? istr[ax] : 0)) & 64'hFFFF_FFFF;
            end else if (!bad) begin
               st = longint'(m_starts[16*d +: 16]);
               stp = longint'($signed(m_steps[16*d +: 16]));
               lim = longint'(m_in_dims[16*d +: 16]);
               x = st + coord[d] * stp;
               if (x < 0 || x >= lim) bad = 1;
               else acc = (acc + x * istr[d]) & 64'hFFFF_FFFF;
            end
         end
      end
      r.in_index = bad ? 32'd0 : acc[31:0];
      r.out_of_range = bad;
      return r;
   endfunction

   // stops offering and waits until every sent word has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (src_addr_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(tgim_pkg::csr_reg_type idx, logic [63:0] val);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         tgim_pkg::REG_MODE:   m_mode = val[0];
         tgim_pkg::REG_RANK:   m_rank = val[2:0];
         tgim_pkg::REG_INDIMS: m_in_dims = val;
         tgim_pkg::REG_OUTDIM: m_out_dims = val;
         tgim_pkg::REG_PERM:   m_perm = val[7:0];
         tgim_pkg::REG_STARTS: m_starts = val;
         tgim_pkg::REG_STEPS:  m_steps = val;
         default: ;
      endcase
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back words need no gap
   task automatic send_word(logic [31:0] oidx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.out_index <= oidx;
      do @(posedge clock); while (!req_ch.ready);
      src_addr_q.push_back(map_index(oidx));
      words_in++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      src_addr_type exp_w;
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL tensor_gather_index_map");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_out++;
         if (rsp_ch.out_of_range) flagged++;
         if (src_addr_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word idx=%h oor=%b",
                                       rsp_ch.in_index, rsp_ch.out_of_range);
         end else begin
            exp_w = src_addr_q.pop_front();
            if (exp_w.in_index !== rsp_ch.in_index ||
                exp_w.out_of_range !== rsp_ch.out_of_range) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp idx=%h oor=%b got idx=%h oor=%b",
                           exp_w.in_index, exp_w.out_of_range,
                           rsp_ch.in_index, rsp_ch.out_of_range);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [63:0] rand_dims(int maxd);
      logic [63:0] v;
      for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(maxd, 1));
      return v;
   endfunction

   function automatic logic [31:0] elem_total();
      longint n;
      int rk;
      rk = (m_rank == 0) ? 1 : (m_rank > 4 ? 4 : int'(m_rank));
      n = 1;
      for (int d = 0; d < rk; d++) n = n * longint'(m_out_dims[16*d +: 16]);
      return (n > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
   endfunction

   task automatic send_random(int n);
      logic [31:0] cnt;
      cnt = elem_total();
      repeat (n) begin
         if (cnt != 0 && $urandom_range(9) < 8)
            send_word($urandom_range(cnt - 1));
         else if ($urandom_range(1)) send_word(cnt + $urandom_range(3));
         else send_word($urandom);
      end
   endtask

   task automatic test_reset_defaults();
      // out dims all zero after reset: every word is flagged
      send_word(32'd0);
      send_word(32'hFFFF_FFFF);
      send_word(32'h5555_AAAA);
      drain();
   endtask

   task automatic test_transpose_directed();
      write_reg(tgim_pkg::REG_MODE, 64'(tgim_pkg::MODE_TRANSPOSE));
      write_reg(tgim_pkg::REG_RANK, 64'd4);
      write_reg(tgim_pkg::REG_INDIMS, {16'd5, 16'd4, 16'd3, 16'd2});
      write_reg(tgim_pkg::REG_OUTDIM, {16'd2, 16'd3, 16'd4, 16'd5});
      write_reg(tgim_pkg::REG_PERM, 64'(8'b00_01_10_11));
      send_word(32'd0);
      send_word(32'd1);
      send_word(32'd119);
      send_word(32'd120);
      send_word(32'hFFFF_FFFF);
      // axis numbers at or above the rank give stride zero
      write_reg(tgim_pkg::REG_RANK, 64'd2);
      write_reg(tgim_pkg::REG_PERM, 64'(8'b11_11_10_01));
      send_word(32'd7);
      send_word(32'd12);
      // rank zero and rank above the maximum
      write_reg(tgim_pkg::REG_RANK, 64'd0);
      send_word(32'd1);
      send_word(32'd2);
      write_reg(tgim_pkg::REG_RANK, 64'd7);
      send_word(32'd33);
      drain();
   endtask

   task automatic test_slice_directed();
      write_reg(tgim_pkg::REG_MODE, 64'(tgim_pkg::MODE_SLICE));
      write_reg(tgim_pkg::REG_RANK, 64'd4);
      write_reg(tgim_pkg::REG_INDIMS, {16'hFFFF, 16'd10, 16'd10, 16'd8});
      write_reg(tgim_pkg::REG_OUTDIM, {16'hFFFF, 16'd3, 16'd4, 16'd2});
      write_reg(tgim_pkg::REG_STARTS, {16'd0, 16'd9, 16'd1, 16'd7});
      write_reg(tgim_pkg::REG_STEPS, {16'h0001, 16'hFFFD, 16'd2, 16'hFFF9});
      send_word(32'd0);
      send_word(32'd65534);
      send_word(32'd65535 * 3);   // carries into the middle axes
      send_word(32'd65535 * 11);  // nonzero coordinates on both middle axes
      // negative and full-scale steps, starts past the input size
      write_reg(tgim_pkg::REG_STEPS, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
      write_reg(tgim_pkg::REG_STARTS, {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
      send_word(32'd0);
      send_word(32'd1);
      send_word(32'h7FFF_FFFF);
      drain();
   endtask

   task automatic test_random_phase(bit slice_mode, int maxd, int n);
      write_reg(tgim_pkg::REG_MODE, 64'(slice_mode));
      write_reg(tgim_pkg::REG_RANK, 64'($urandom_range(4, 1)));
      write_reg(tgim_pkg::REG_INDIMS, rand_dims(maxd));
      write_reg(tgim_pkg::REG_OUTDIM, rand_dims(maxd));
      write_reg(tgim_pkg::REG_PERM, 64'($urandom_range(255)));
      write_reg(tgim_pkg::REG_STARTS, {$urandom, $urandom} & {4{16'(maxd)}});
      write_reg(tgim_pkg::REG_STEPS, {$urandom, $urandom} & 64'h8003_8003_8003_8003);
      send_random(n);
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (LATENCY * 3) @(negedge clock);
            recv_hold = 1'b0;
         end
         send_random(80);
      join
      drain();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.out_index = '0;
      rsp_ch.ready = 1'b0;
      m_mode = tgim_pkg::MODE_TRANSPOSE;
      m_rank = 3'd1;
      m_in_dims = '0;
      m_out_dims = '0;
      m_perm = 8'd228;
      m_starts = '0;
      m_steps = 64'h0001_0001_0001_0001;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_transpose_directed();
      test_slice_directed();
      send_idle_pct = 30;
      recv_idle_pct = 48;
      test_random_phase(1'b0, 12, 100);
      test_random_phase(1'b1, 12, 100);
      send_idle_pct = 48;
      recv_idle_pct = 30;
      test_random_phase(1'b0, 65535, 60);
      test_random_phase(1'b1, 9, 100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_phase(1'b1, 6, 100);
      test_backpressure();
      test_random_phase(1'b0, 7, 80);

      $display("covered %0d index words (%0d flagged) in transpose and slice modes,",
               words_in, flagged);
      $display("ranks 0..7, full-scale dims and steps, stalls and a long output hold");
      if (errors == 0 && words_out == words_in) begin
         $display("PASS tensor_gather_index_map");
      end else begin
         $display("%0d mismatches, %0d words in, %0d out", errors, words_in, words_out);
         $display("FAIL tensor_gather_index_map");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/tgim_pkg.sv
src/tgim_if.sv
src/tgim_stride.sv
src/tgim_decode.sv
src/tgim_map.sv
src/tensor_gather_index_map.sv
tb/tb.sv
